FILE: rtl/perlin_noise_2d_macros.svh
// Assertion macros shared by the perlin noise RTL
`ifndef PERLIN_NOISE_2D_MACROS_SVH
`define PERLIN_NOISE_2D_MACROS_SVH

// Clocked assertion, checked outside reset
`define PN2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion, checked on every edge including reset
`define PN2D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/pn2d_pkg.sv
// Shared types, constants and helper functions for the 2D gradient noise block
`default_nettype none
package pn2d_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int TAB_AW        = $clog2(TABLE_SIZE);
    localparam int FRACTION_BITS = 16;
    localparam int COORD_W       = 32;
    localparam int NOISE_W       = 18;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Gradient selectors
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_MP = 2'd1;
    localparam logic [1:0] GRAD_MM = 2'd2;
    localparam logic [1:0] GRAD_PM = 2'd3;

    // 10.0 in fade arithmetic, 20 bits wide
    localparam logic [19:0] FADE_TEN = 20'd10 << FRACTION_BITS;
    localparam logic signed [18:0] FX_ONE = 19'sd1 <<< FRACTION_BITS;

    // Command carried from the front end to the back end
    typedef struct packed {
        logic                     is_load;
        logic [TAB_AW-1:0]        idx;
        logic [7:0]               val;
        logic [TAB_AW-1:0]        xi;
        logic [TAB_AW-1:0]        yi;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fy;
    } t_cmd;

    // Dot product of a diagonal gradient with a corner offset
    function automatic logic signed [18:0] grad_dot(input logic [1:0] h,
                                                   input logic signed [18:0] dx,
                                                   input logic signed [18:0] dy);
        logic signed [18:0] r;
        unique case (h)
            GRAD_PP: r = dx + dy;
            GRAD_MP: r = dy - dx;
            GRAD_MM: r = -dx - dy;
            GRAD_PM: r = dx - dy;
            default: r = dx + dy;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pn2d_front.sv
// Front end: accepts input transactions, classifies them and splits coordinates
`default_nettype none
module pn2d_front
    import pn2d_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [7:0]                i_table_index,
    input  wire logic [7:0]                i_table_value,
    input  wire logic signed [COORD_W-1:0] i_x_coord,
    input  wire logic signed [COORD_W-1:0] i_y_coord,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output t_cmd                           o_cmd
);

    logic r_fv;
    logic n_fv;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = r_fv && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_fv && !i_q_full;
    assign o_cmd      = r_cmd;

    // Classify and split the incoming transaction
    always_comb begin
        n_cmd.is_load = (i_operation == OP_LOAD);
        n_cmd.idx     = i_table_index[TAB_AW-1:0];
        n_cmd.val     = i_table_value;
        n_cmd.xi      = i_x_coord[FRACTION_BITS +: TAB_AW];
        n_cmd.yi      = i_y_coord[FRACTION_BITS +: TAB_AW];
        n_cmd.fx      = i_x_coord[FRACTION_BITS-1:0];
        n_cmd.fy      = i_y_coord[FRACTION_BITS-1:0];
    end

    // Hold the item until the queue takes it
    always_comb begin
        n_fv = r_fv;
        if (accept) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pn2d_queue.sv
// Short command queue between the front end and the back end
`default_nettype none
`include "perlin_noise_2d_macros.svh"
module pn2d_queue
    import pn2d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_nonempty,
    output t_cmd      o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full     = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `PN2D_ASSERT(a_cnt_bound, r_cnt <= (Q_AW+1)'(Q_DEPTH), "queue count overflow")
    `PN2D_ASSERT(a_no_pop_empty, i_pop |-> o_nonempty, "pop from empty queue")
    `PN2D_ASSERT(a_no_push_full, i_push |-> !o_full, "push into full queue")

endmodule
`default_nettype wire

FILE: rtl/pn2d_back.sv
// Back end: table writes, corner hashing, fade curves and bilinear blend
`default_nettype none
`include "perlin_noise_2d_macros.svh"
module pn2d_back
    import pn2d_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_nonempty,
    input  wire t_cmd                i_cmd,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [NOISE_W-1:0] o_noise_value
);

    localparam int F = FRACTION_BITS;

    // Three copies of the table, two read ports each
    logic [7:0] r_tab_a [TABLE_SIZE];
    logic [7:0] r_tab_b [TABLE_SIZE];
    logic [7:0] r_tab_c [TABLE_SIZE];

    logic ce;
    logic wr;

    // Stage 1
    logic              r1_v;
    logic [7:0]        r1_pa0, r1_pa1;
    logic [TAB_AW-1:0] r1_yi;
    logic [F-1:0]      r1_fx, r1_fy;
    logic [2*F-1:0]    r1_sqx, r1_sqy;
    // Stage 2
    logic              r2_v;
    logic [7:0]        r2_hbl, r2_htl, r2_hbr, r2_htr;
    logic [F-1:0]      r2_fx, r2_fy, r2_ax, r2_ay;
    logic [2*F-1:0]    r2_bx, r2_by;
    // Stage 3
    logic              r3_v;
    logic signed [18:0] r3_bl, r3_br, r3_tl, r3_tr;
    logic [35:0]       r3_px, r3_py;
    // Stage 4
    logic              r4_v;
    logic signed [18:0] r4_bl, r4_br;
    logic signed [40:0] r4_mlo, r4_mhi;
    logic [19:0]       r4_u;
    // Stage 5
    logic              r5_v;
    logic signed [25:0] r5_lo;
    logic signed [26:0] r5_d;
    logic [19:0]       r5_u;
    // Stage 6
    logic              r6_v;
    logic signed [25:0] r6_lo;
    logic signed [47:0] r6_m;
    // Output
    logic              r_out_valid;
    logic signed [NOISE_W-1:0] r_noise;

    // Combinational helpers
    logic [TAB_AW-1:0]  a0, a1;
    logic [F-1:0]       ax, ay, bx, by;
    logic [21:0]        cx_w, cy_w;
    logic signed [18:0] sx, sy, sxm, sym;
    logic [19:0]        u, v;
    logic signed [19:0] dlo, dhi;
    logic signed [25:0] lo, hi;
    logic signed [32:0] res;

    assign ce    = !(r_out_valid && i_out_stall);
    assign o_pop = ce && i_q_nonempty;
    assign wr    = o_pop && i_cmd.is_load;

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

    // Write all table copies on a load
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_tab_a[i_cmd.idx] <= i_cmd.val;
            r_tab_b[i_cmd.idx] <= i_cmd.val;
            r_tab_c[i_cmd.idx] <= i_cmd.val;
        end
    end

    // Stage 1: first level hash reads, square of fractions
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_pa0 <= r_tab_a[i_cmd.xi];
            r1_pa1 <= r_tab_a[i_cmd.xi + 1'b1];
            r1_yi  <= i_cmd.yi;
            r1_fx  <= i_cmd.fx;
            r1_fy  <= i_cmd.fy;
            r1_sqx <= i_cmd.fx * i_cmd.fx;
            r1_sqy <= i_cmd.fy * i_cmd.fy;
        end
    end

    // Stage 2: second level hash reads, cube term
    assign a0 = r1_pa0[TAB_AW-1:0] + r1_yi;
    assign a1 = r1_pa1[TAB_AW-1:0] + r1_yi;
    assign ax = r1_sqx[2*F-1:F];
    assign ay = r1_sqy[2*F-1:F];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_hbl <= r_tab_b[a0];
            r2_htl <= r_tab_b[a0 + 1'b1];
            r2_hbr <= r_tab_c[a1];
            r2_htr <= r_tab_c[a1 + 1'b1];
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_ax  <= ax;
            r2_ay  <= ay;
            r2_bx  <= ax * r1_fx;
            r2_by  <= ay * r1_fy;
        end
    end

    // Stage 3: corner dot products, fade product
    assign bx   = r2_bx[2*F-1:F];
    assign by   = r2_by[2*F-1:F];
    assign cx_w = ({6'd0, r2_ax} << 2) + ({6'd0, r2_ax} << 1) + {2'd0, FADE_TEN}
                  - (({6'd0, r2_fx} << 4) - {6'd0, r2_fx});
    assign cy_w = ({6'd0, r2_ay} << 2) + ({6'd0, r2_ay} << 1) + {2'd0, FADE_TEN}
                  - (({6'd0, r2_fy} << 4) - {6'd0, r2_fy});
    assign sx   = signed'({3'd0, r2_fx});
    assign sy   = signed'({3'd0, r2_fy});
    assign sxm  = sx - FX_ONE;
    assign sym  = sy - FX_ONE;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_bl <= grad_dot(r2_hbl[1:0], sx,  sy);
            r3_br <= grad_dot(r2_hbr[1:0], sxm, sy);
            r3_tl <= grad_dot(r2_htl[1:0], sx,  sym);
            r3_tr <= grad_dot(r2_htr[1:0], sxm, sym);
            r3_px <= bx * cx_w[19:0];
            r3_py <= by * cy_w[19:0];
        end
    end

    // Stage 4: weight the vertical differences
    assign u   = r3_px[F +: 20];
    assign v   = r3_py[F +: 20];
    assign dlo = 20'(r3_tl) - 20'(r3_bl);
    assign dhi = 20'(r3_tr) - 20'(r3_br);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_mlo <= signed'({1'b0, v}) * dlo;
            r4_mhi <= signed'({1'b0, v}) * dhi;
            r4_bl  <= r3_bl;
            r4_br  <= r3_br;
            r4_u   <= u;
        end
    end

    // Stage 5: finish the vertical blends
    assign lo = 26'(r4_bl) + 26'(r4_mlo >>> F);
    assign hi = 26'(r4_br) + 26'(r4_mhi >>> F);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_lo <= lo;
            r5_d  <= 27'(hi) - 27'(lo);
            r5_u  <= r4_u;
        end
    end

    // Stage 6: weight the horizontal difference
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_m  <= signed'({1'b0, r5_u}) * r5_d;
            r6_lo <= r5_lo;
        end
    end

    // Output: finish the blend and saturate
    assign res = 33'(r6_lo) + 33'(r6_m >>> F);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (res > 33'sd131071) begin
                r_noise <= 18'sd131071;
            end else if (res < -33'sd131072) begin
                r_noise <= -18'sd131072;
            end else begin
                r_noise <= res[NOISE_W-1:0];
            end
        end
    end

    // Advance valid bits; loads end at the table write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r1_v        <= o_pop && !i_cmd.is_load;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r6_v        <= r5_v;
            r_out_valid <= r6_v;
        end
    end

    `PN2D_ASSERT(a_load_no_result, wr |=> !r1_v, "load transaction entered the datapath")
    `PN2D_ASSERT(a_freeze, !ce |=> ($stable(r1_v) && $stable(r6_v)), "pipeline moved while held")
    `PN2D_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_noise_value)), "held result changed")

endmodule
`default_nettype wire

FILE: rtl/perlin_noise_2d.sv
// Path from input acceptance to output valid: front-end register, queue, back-end stages 1 to 6, output register.
// Throughput: one transaction per cycle while the output is not held, loads and evaluations alike.
// Rate is set by the seven-stage back-end pipeline and the three dual-read table copies.
// A four-entry queue decouples the front end; a held output freezes the back end.
// Reset (synchronous, active low) clears all valid bits and the queue; the table is not cleared.
`default_nettype none
module perlin_noise_2d
    import pn2d_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [7:0]                i_table_index,
    input  wire logic [7:0]                i_table_value,
    input  wire logic signed [COORD_W-1:0] i_x_coord,
    input  wire logic signed [COORD_W-1:0] i_y_coord,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [NOISE_W-1:0]      o_noise_value
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_nonempty;
    t_cmd f_cmd;
    t_cmd q_cmd;

    pn2d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (f_cmd)
    );

    pn2d_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (f_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_cmd      (q_cmd)
    );

    pn2d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_noise_value (o_noise_value)
    );

endmodule
`default_nettype wire

FILE: bench/perlin_noise_2d_checker.sv
// Checker for the 2D gradient noise block: table shadow, noise prediction, compare
`timescale 1ns / 100ps
`default_nettype none
module perlin_noise_2d_checker
    import pn2d_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [7:0]                i_table_index,
    input  wire logic [7:0]                i_table_value,
    input  wire logic signed [COORD_W-1:0] i_x_coord,
    input  wire logic signed [COORD_W-1:0] i_y_coord,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic signed [NOISE_W-1:0] i_noise_value,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results_seen,
    output int                             o_accepts
);

    localparam longint ONE = longint'(1) << FRACTION_BITS;

    logic [7:0]               perm_shadow [TABLE_SIZE];
    logic signed [NOISE_W-1:0] noise_queue [$];

    // Floor division by 2^F
    function automatic longint fx_floor(input longint v);
        return v >>> FRACTION_BITS;
    endfunction

    function automatic longint fade_of(input longint t);
        longint a, b, c;
        a = (t * t) >> FRACTION_BITS;
        b = (a * t) >> FRACTION_BITS;
        c = 6 * a + 10 * ONE - 15 * t;
        return (b * c) >> FRACTION_BITS;
    endfunction

    function automatic longint mix(input longint w, input longint p, input longint q);
        return p + fx_floor(w * (q - p));
    endfunction

    function automatic longint gdot(input logic [7:0] h, input longint dx,
                                    input longint dy);
        case (h[1:0])
            GRAD_PP: return dx + dy;
            GRAD_MP: return dy - dx;
            GRAD_MM: return -dx - dy;
            default: return dx - dy;
        endcase
    endfunction

    function automatic logic [7:0] hash_at(input logic [7:0] xi, input logic [7:0] yi);
        logic [7:0] first;
        first = perm_shadow[xi];
        return perm_shadow[8'(first + yi)];
    endfunction

    function automatic logic signed [NOISE_W-1:0] noise_at(input logic signed [31:0] x,
                                                          input logic signed [31:0] y);
        logic [7:0] xi, yi;
        longint fx, fy, u, v, bl, br, tl, tr, lo, hi, r;
        xi = x[FRACTION_BITS+7:FRACTION_BITS];
        yi = y[FRACTION_BITS+7:FRACTION_BITS];
        fx = longint'(x[FRACTION_BITS-1:0]);
        fy = longint'(y[FRACTION_BITS-1:0]);
        bl = gdot(hash_at(xi, yi), fx, fy);
        br = gdot(hash_at(xi + 8'd1, yi), fx - ONE, fy);
        tl = gdot(hash_at(xi, yi + 8'd1), fx, fy - ONE);
        tr = gdot(hash_at(xi + 8'd1, yi + 8'd1), fx - ONE, fy - ONE);
        u = fade_of(fx);
        v = fade_of(fy);
        lo = mix(v, bl, tl);
        hi = mix(v, br, tr);
        r = mix(u, lo, hi);
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return NOISE_W'(r);
    endfunction

    assign o_pending = noise_queue.size();

    // Track input transactions and compare output transactions
    always @(posedge i_clk) begin
        logic signed [NOISE_W-1:0] want;
        if (!i_rst_n) begin
            o_errors       <= 0;
            o_results_seen <= 0;
            o_accepts      <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                o_accepts <= o_accepts + 1;
                if (i_operation == OP_LOAD)
                    perm_shadow[i_table_index] = i_table_value;
                else
                    noise_queue.push_back(noise_at(i_x_coord, i_y_coord));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (noise_queue.size() == 0) begin
                    $display("%0t: unexpected noise %0d", $time, i_noise_value);
                    o_errors <= o_errors + 1;
                end else begin
                    want = noise_queue.pop_front();
                    if (want !== i_noise_value) begin
                        $display("%0t: noise mismatch expected %0d actual %0d",
                                 $time, want, i_noise_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: bench/perlin_noise_2d_tb.sv
// Testbench top for the 2D gradient noise block: stimulus, idling and verdict
`timescale 1ns / 100ps
`default_nettype none
module perlin_noise_2d_tb;
    import pn2d_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_LEN    = 60;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      op = OP_LOAD;
    logic [7:0]                tab_idx = '0;
    logic [7:0]                tab_val = '0;
    logic signed [COORD_W-1:0] x_pos = '0;
    logic signed [COORD_W-1:0] y_pos = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [NOISE_W-1:0] noise;
    int  errors, pending, results_seen, accepts;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_count = 0;
    int  quiet_cycles = 0;
    int  evals_sent = 0;
    int  loads_sent = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    perlin_noise_2d u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(op), .i_table_index(tab_idx), .i_table_value(tab_val),
        .i_x_coord(x_pos), .i_y_coord(y_pos),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_noise_value(noise)
    );

    perlin_noise_2d_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_operation(op),
        .i_table_index(tab_idx), .i_table_value(tab_val),
        .i_x_coord(x_pos), .i_y_coord(y_pos),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_noise_value(noise),
        .o_errors(errors), .o_pending(pending), .o_results_seen(results_seen),
        .o_accepts(accepts)
    );

    // Drive receiver stall: one long hold-off once asked, else random
    always @(posedge clk) begin
        if (hold_req && hold_count < HOLD_LEN) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("perlin_noise_2d_tb NOT OK");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send(input logic o, input logic [7:0] i, input logic [7:0] v,
                        input logic [31:0] x, input logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        tab_idx  <= i;
        tab_val  <= v;
        x_pos    <= x;
        y_pos    <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (o == OP_EVAL) evals_sent++;
        else loads_sent++;
    endtask

    task automatic evaluate(input logic [31:0] x, input logic [31:0] y);
        send(OP_EVAL, 8'($urandom), 8'($urandom), x, y);
    endtask

    // Random point: mostly near the origin, sometimes full range
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{12{1'b1}}, 20'($urandom)};
            default: return {12'd0, 20'($urandom)};
        endcase
    endfunction

    task automatic load_table(input bit identity);
        logic [7:0] perm [256];
        int j;
        logic [7:0] t;
        for (int k = 0; k < 256; k++) perm[k] = k[7:0];
        if (!identity)
            for (int k = 255; k > 0; k--) begin
                j = $urandom_range(k);
                t = perm[k]; perm[k] = perm[j]; perm[j] = t;
            end
        for (int k = 0; k < 256; k++) send(OP_LOAD, k[7:0], perm[k], $urandom, $urandom);
    endtask

    // Drop valid and wait for every result to come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0)
                send(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
            else
                evaluate(pick_coord(), pick_coord());
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity table, extremes and other picked coordinates, two table rewrites
        load_table(1'b1);
        evaluate(32'h0000_0000, 32'h0000_0000);
        evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        evaluate(32'h8000_0000, 32'h8000_0000);
        evaluate(32'h8000_0000, 32'h7FFF_FFFF);
        evaluate(32'hFFFF_FFFF, 32'h0000_FFFF);
        evaluate(32'h0000_8000, 32'h0000_8000);
        evaluate(32'hFFFF_8000, 32'h0001_4000);
        evaluate(32'h00FF_FFFF, 32'hFF00_0001);
        evaluate(32'hAAAA_5555, 32'h5555_AAAA);
        evaluate(32'h0000_0001, 32'hFFFF_0000);
        send(OP_LOAD, 8'hFF, 8'h00, '0, '0);
        send(OP_LOAD, 8'h00, 8'hFF, '0, '0);
        evaluate(32'h00FF_C000, 32'h00FF_2000);
        evaluate(32'h0000_3000, 32'hFFFF_F000);
        drain();

        // Shuffled table, sender light / receiver heavy idling
        load_table(1'b0);
        send_idle_pct = 14;
        recv_idle_pct = 78;
        random_phase(420);
        drain();

        // Back-pressure: receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        random_phase(40);
        drain();

        send_idle_pct = 78;
        recv_idle_pct = 14;
        random_phase(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(420);
        drain();

        $display("covered %0d loads and %0d evaluations (%0d accepted), %0d results checked",
                 loads_sent, evals_sent, accepts, results_seen);
        $display("idling both ways, a long receiver hold-off and full-rate streaming");
        if (errors == 0 && pending == 0) begin
            $display("perlin_noise_2d_tb OK");
        end else begin
            $display("perlin_noise_2d_tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/pn2d_pkg.sv
rtl/pn2d_front.sv
rtl/pn2d_queue.sv
rtl/pn2d_back.sv
rtl/perlin_noise_2d.sv
bench/perlin_noise_2d_checker.sv
bench/perlin_noise_2d_tb.sv
